### rtl/sacr_pkg.sv
package sacr_pkg;

    // Default build settings
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    // Character codes
    localparam logic [7:0] CH_S    = 8'h53;
    localparam logic [7:0] CH_C    = 8'h43;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // Job handed from the parser side to the formatter side
    typedef struct packed {
        logic       start;   // start-request job, else a response run
        logic [2:0] chan;    // channel chosen when the job was queued
    } cmd_t;

    // Decimal digit of a value below ten units: count the multiples passed.
    function automatic logic [3:0] digit_count(input logic [9:0] value,
                                               input logic [9:0] unit);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({4'b0, value} >= 14'(k) * {4'b0, unit})
            begin
                n = n + 4'd1;
            end
        end
        return n;
    endfunction

endpackage

### rtl/sacr_front.sv
module sacr_front #(
    parameter int SAMPLE_BITS = sacr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     mode,
    input  logic [7:0]               rx_byte,
    input  logic [SAMPLE_BITS-1:0]   sample_one,
    input  logic [SAMPLE_BITS-1:0]   sample_two,
    input  logic [SAMPLE_BITS-1:0]   sample_three,
    input  logic [SAMPLE_BITS-1:0]   sample_four,
    input  logic                     q_full,
    output logic                     push,
    output sacr_pkg::cmd_t           cmd,
    output logic [SAMPLE_BITS-1:0]   sample_sel,
    output logic [SAMPLE_BITS-1:0]   quot_est,
    output logic [SAMPLE_BITS+6:0]   duty_prod
);

    localparam int QSHIFT = SAMPLE_BITS + 10;
    localparam int QPW    = 2 * SAMPLE_BITS + 11;
    localparam logic [QPW-1:0] RECIP_1000 = QPW'((2 ** QSHIFT) / 1000);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DIGIT = 2'd1;
    localparam logic [1:0] PH_CR    = 2'd2;

    localparam logic [7:0] CH_ZERO_P1 = sacr_pkg::CH_ZERO + 8'd1;
    localparam logic [7:0] CH_ZERO_P4 = sacr_pkg::CH_ZERO + 8'd4;

    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic [2:0]     chan_reg;
    logic [2:0]     chan_next;
    logic           accept;
    logic [QPW-1:0] quot_prod;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        phase_next = phase_reg;
        chan_next  = chan_reg;
        if (accept && !mode)
        begin
            unique case (phase_reg)
                PH_DIGIT:
                begin
                    if (rx_byte >= CH_ZERO_P1 && rx_byte <= CH_ZERO_P4)
                    begin
                        chan_next  = 3'(rx_byte - sacr_pkg::CH_ZERO);
                        phase_next = PH_CR;
                    end
                    else
                    begin
                        chan_next  = 3'd0;
                        phase_next = PH_IDLE;
                    end
                end
                PH_CR:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = (rx_byte == sacr_pkg::CH_S) ? PH_DIGIT : PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            chan_reg  <= 3'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            chan_reg  <= chan_next;
        end
    end

    // Queue a start request on a closing CR, a response run on a completion with a channel
    assign push = accept && ((!mode && phase_reg == PH_CR && rx_byte == sacr_pkg::CH_CR)
                             || (mode && chan_reg != 3'd0));

    assign cmd.start = !mode;
    assign cmd.chan  = chan_reg;

    always_comb
    begin
        case (chan_reg)
            3'd1:    sample_sel = sample_one;
            3'd2:    sample_sel = sample_two;
            3'd3:    sample_sel = sample_three;
            3'd4:    sample_sel = sample_four;
            default: sample_sel = '0;
        endcase
    end

    // Quotient estimate by 1000, low by at most one; duty numerator
    assign quot_prod = QPW'(sample_sel) * RECIP_1000;
    assign quot_est  = SAMPLE_BITS'(quot_prod >> QSHIFT);
    assign duty_prod = (SAMPLE_BITS + 7)'(sample_sel) * (SAMPLE_BITS + 7)'(100);

endmodule

### rtl/sacr_fifo.sv
module sacr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = sacr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

### rtl/sacr_back.sv
module sacr_back #(
    parameter int SAMPLE_BITS = sacr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  sacr_pkg::cmd_t         head_cmd,
    input  logic [SAMPLE_BITS-1:0] head_sample,
    input  logic [SAMPLE_BITS-1:0] head_quot,
    input  logic [SAMPLE_BITS+6:0] head_duty_prod,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   start_request,
    output logic                   byte_valid,
    output logic [7:0]             tx_byte,
    output logic                   last,
    output logic [2:0]             led_select,
    output logic [6:0]             led_duty
);

    localparam int N  = SAMPLE_BITS;
    localparam int RW = (N + 1 > 11) ? N + 1 : 11;
    localparam logic [RW-1:0] THOUSAND = RW'(1000);
    localparam logic [N:0]    FULL     = {1'b0, {N{1'b1}}};

    localparam logic [2:0] ST_THOU = 3'd1;
    localparam logic [2:0] ST_HUND = 3'd2;
    localparam logic [2:0] ST_TENS = 3'd3;
    localparam logic [2:0] ST_ONES = 3'd4;
    localparam logic [2:0] ST_CR   = 3'd5;
    localparam logic [2:0] ST_LF   = 3'd6;

    logic       busy_reg,  busy_next;
    logic [2:0] step_reg,  step_next;
    logic [2:0] chan_reg,  chan_next;
    logic [6:0] duty_reg,  duty_next;
    logic [9:0] rem_reg,   rem_next;
    logic [3:0] dig_reg,   dig_next;

    logic       out_valid_reg, out_valid_next;
    logic       out_start_reg, out_start_next;
    logic       out_bv_reg,    out_bv_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_last_reg,  out_last_next;
    logic [2:0] out_led_reg,   out_led_next;
    logic [6:0] out_duty_reg,  out_duty_next;

    logic          advance;
    logic [RW-1:0] r0;
    logic          fix;
    logic [9:0]    rem_first;
    logic [N:0]    quot_fixed;
    logic [3:0]    dig_first;
    logic [6:0]    dq0;
    logic [N:0]    rd;
    logic [6:0]    duty_first;
    logic [3:0]    dig_step;

    // Correct the quotient estimate; thousands digit saturates at nine
    assign r0         = RW'(head_sample) - RW'(head_quot) * THOUSAND;
    assign fix        = (r0 >= THOUSAND);
    assign rem_first  = 10'(fix ? r0 - THOUSAND : r0);
    assign quot_fixed = (N + 1)'(head_quot) + (N + 1)'(fix);
    assign dig_first  = (quot_fixed > (N + 1)'(9)) ? 4'd9 : quot_fixed[3:0];

    // Duty: estimate by shift, add one where the remainder reaches full scale
    assign dq0        = head_duty_prod[N+6:N];
    assign rd         = (N + 1)'(head_duty_prod[N-1:0]) + (N + 1)'(dq0);
    assign duty_first = dq0 + 7'(rd >= FULL);

    assign dig_step = sacr_pkg::digit_count(rem_reg, (step_reg == ST_THOU) ? 10'd100 : 10'd10);

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && !busy_reg && !q_empty;

    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        chan_next      = chan_reg;
        duty_next      = duty_reg;
        rem_next       = rem_reg;
        dig_next       = dig_reg;
        out_valid_next = out_valid_reg;
        out_start_next = out_start_reg;
        out_bv_next    = out_bv_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_led_next   = out_led_reg;
        out_duty_next  = out_duty_reg;
        if (advance)
        begin
            if (busy_reg)
            begin
                out_valid_next = 1'b1;
                out_start_next = 1'b0;
                out_bv_next    = 1'b1;
                out_last_next  = (step_reg == ST_LF);
                out_led_next   = chan_reg;
                out_duty_next  = duty_reg;
                out_byte_next  = sacr_pkg::CH_ZERO + {4'b0, dig_reg};
                step_next      = step_reg + 3'd1;
                unique case (step_reg)
                    ST_THOU, ST_HUND:
                    begin
                        dig_next = dig_step;
                        rem_next = rem_reg - 10'(14'(dig_step)
                                   * ((step_reg == ST_THOU) ? 14'd100 : 14'd10));
                    end
                    ST_TENS:
                    begin
                        dig_next = rem_reg[3:0];
                    end
                    ST_ONES:
                    begin
                        dig_next = dig_reg;
                    end
                    ST_CR:
                    begin
                        out_byte_next = sacr_pkg::CH_CR;
                    end
                    ST_LF:
                    begin
                        out_byte_next = sacr_pkg::CH_LF;
                        busy_next     = 1'b0;
                    end
                    default:
                    begin
                        out_byte_next = sacr_pkg::CH_LF;
                        busy_next     = 1'b0;
                    end
                endcase
            end
            else if (!q_empty)
            begin
                out_valid_next = 1'b1;
                if (head_cmd.start)
                begin
                    out_start_next = 1'b1;
                    out_bv_next    = 1'b0;
                    out_byte_next  = 8'd0;
                    out_last_next  = 1'b1;
                    out_led_next   = 3'd0;
                    out_duty_next  = 7'd0;
                end
                else
                begin
                    out_start_next = 1'b0;
                    out_bv_next    = 1'b1;
                    out_byte_next  = sacr_pkg::CH_C;
                    out_last_next  = 1'b0;
                    out_led_next   = head_cmd.chan;
                    out_duty_next  = duty_first;
                    busy_next      = 1'b1;
                    step_next      = ST_THOU;
                    chan_next      = head_cmd.chan;
                    duty_next      = duty_first;
                    rem_next       = rem_first;
                    dig_next       = dig_first;
                end
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= ST_THOU;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chan_reg     <= chan_next;
        duty_reg     <= duty_next;
        rem_reg      <= rem_next;
        dig_reg      <= dig_next;
        out_start_reg <= out_start_next;
        out_bv_reg    <= out_bv_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_led_reg   <= out_led_next;
        out_duty_reg  <= out_duty_next;
    end

    assign out_valid     = out_valid_reg;
    assign start_request = out_start_reg;
    assign byte_valid    = out_bv_reg;
    assign tx_byte       = out_byte_reg;
    assign last          = out_last_reg;
    assign led_select    = out_led_reg;
    assign led_duty      = out_duty_reg;

endmodule

### rtl/serial_adc_command_responder_unit.sv
// Serial command parser and sample reporter.
// Input channel (in_valid / in_stall): mode 0 carries a received byte in
// rx_byte, mode 1 a conversion-complete event with four samples. The parser
// takes 'S', a digit '1'..'4' (the channel) and CR; the CR yields one
// transfer with start_request set and last set.
// A completion with a channel chosen yields seven transfers: 'C', four
// decimal digits, CR, LF, each with led_select and led_duty of that channel;
// last marks the LF. Without a chosen channel it yields nothing.
// An accepted job passes through the job queue and then the output register
// when the output side is free. The front takes one item per cycle while
// the job queue has room; the formatter drains a start request as one
// transfer and a response run as seven, taking no new job during a run,
// so completions are limited by the single output register of the formatter.
// Stall on the output holds the output register and the formatter; the
// queue then fills and in_stall rises. Parser bytes that cause no job
// still wait for queue room.
// Reset clears the parser (waiting for 'S', no channel), empties the queue
// and drops out_valid.
module serial_adc_command_responder_unit #(
    parameter int SAMPLE_BITS = sacr_pkg::SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = sacr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic [7:0]             rx_byte,
    input  logic [SAMPLE_BITS-1:0] sample_one,
    input  logic [SAMPLE_BITS-1:0] sample_two,
    input  logic [SAMPLE_BITS-1:0] sample_three,
    input  logic [SAMPLE_BITS-1:0] sample_four,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   start_request,
    output logic                   byte_valid,
    output logic [7:0]             tx_byte,
    output logic                   last,
    output logic [2:0]             led_select,
    output logic [6:0]             led_duty
);

    localparam int CMD_W = $bits(sacr_pkg::cmd_t);
    localparam int QW    = CMD_W + 3 * SAMPLE_BITS + 7;

    sacr_pkg::cmd_t         push_cmd;
    logic [SAMPLE_BITS-1:0] push_sample;
    logic [SAMPLE_BITS-1:0] push_quot;
    logic [SAMPLE_BITS+6:0] push_duty_prod;
    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    logic [QW-1:0]          push_data;
    logic [QW-1:0]          head_data;
    sacr_pkg::cmd_t         head_cmd;
    logic [SAMPLE_BITS-1:0] head_sample;
    logic [SAMPLE_BITS-1:0] head_quot;
    logic [SAMPLE_BITS+6:0] head_duty_prod;

    // Front: parse bytes, classify events, start the arithmetic
    sacr_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .rx_byte      (rx_byte),
        .sample_one   (sample_one),
        .sample_two   (sample_two),
        .sample_three (sample_three),
        .sample_four  (sample_four),
        .q_full       (q_full),
        .push         (push),
        .cmd          (push_cmd),
        .sample_sel   (push_sample),
        .quot_est     (push_quot),
        .duty_prod    (push_duty_prod)
    );

    assign push_data = {push_cmd, push_sample, push_quot, push_duty_prod};

    // Job queue between parser and formatter
    sacr_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {head_cmd, head_sample, head_quot, head_duty_prod} = head_data;

    // Back: finish the divides, emit the transfers
    sacr_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .head_cmd       (head_cmd),
        .head_sample    (head_sample),
        .head_quot      (head_quot),
        .head_duty_prod (head_duty_prod),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .start_request  (start_request),
        .byte_valid     (byte_valid),
        .tx_byte        (tx_byte),
        .last           (last),
        .led_select     (led_select),
        .led_duty       (led_duty)
    );

    // Never write a full queue or read an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full && !pop))
        else $error("job queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("job queue underflow");

    // A start request is a lone transfer with no byte and no LED
    a_start_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && start_request) |-> (!byte_valid && last && led_select == 3'd0))
        else $error("malformed start request transfer");

    // Response bytes always name a real LED and a duty in range
    a_resp_led: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_valid) |-> (led_select != 3'd0 && led_select <= 3'd4
                                       && led_duty <= 7'd100 && !start_request))
        else $error("response transfer with bad LED or duty");

endmodule
